// ===== design/assert_macros.svh =====
// Assertion macros for the runtime loss gradient/Hessian RTL.
// Needs clk and rst_n in the scope where a macro is used.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked check, off while reset is held
`define RLGH_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Clocked check that also holds during reset
`define RLGH_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

// ===== design/rlgh_pkg.sv =====
// Shared types, widths, register codes and sigmoid table builder for the
// runtime loss gradient/Hessian block. No dependencies.
package rlgh_pkg;

  // defaults for top-level parameters
  localparam int FRAC_BITS_DEF = 16;
  localparam int SIG_DEPTH_DEF = 1024;

  // field widths
  localparam int SCORE_W    = 32;
  localparam int TIME_W     = 32;
  localparam int GRAD_W     = 25;
  localparam int HESS_W     = 31;
  localparam int SCALE_W    = 8;
  localparam int CLIP_W     = 24;
  localparam int CFG_DATA_W = 31;
  localparam int CFG_IDX_W  = 2;

  // scaled magnitude is FRAC_BITS + MAG_EXTRA bits wide
  localparam int MAG_EXTRA = 8;
  // magnitude * D >> F always fits in this many bits
  localparam int T_W   = 40;
  localparam int TLO_W = 20;

  // register reset values
  localparam logic [SCALE_W-1:0] RST_SCALE = 8'd20;
  localparam logic [CLIP_W-1:0]  RST_CLIP  = 24'd3276800;
  localparam logic [HESS_W-1:0]  RST_FLOOR = 31'd6554;
  localparam logic [HESS_W-1:0]  RST_CEIL  = 31'd65536000;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_SCALE = 2'd0,
    REG_CLIP  = 2'd1,
    REG_FLOOR = 2'd2,
    REG_CEIL  = 2'd3
  } cfg_reg_t;

  typedef struct packed {
    logic [SCALE_W-1:0] scale;
    logic [CLIP_W-1:0]  clip;
    logic [HESS_W-1:0]  floor_v;
    logic [HESS_W-1:0]  ceil_v;
  } cfg_t;

  // per-sample side data that rides along the pipe
  typedef struct packed {
    logic [TIME_W-1:0] d;     // |ct - rt|
    logic              dpos;  // ct > rt
    logic              last;
  } lane_t;

  // bitwise long division, only used while building the table
  function automatic logic [63:0] udiv(logic [63:0] num, logic [63:0] den);
    logic [64:0] rem;
    logic [63:0] quo;
    int i;
    rem = '0;
    quo = '0;
    for (i = 63; i >= 0; i--) begin
      rem = {rem[63:0], num[i]};
      if (rem >= {1'b0, den}) begin
        rem = rem - {1'b0, den};
        quo[i] = 1'b1;
      end
    end
    return quo;
  endfunction

  // sigmoid table entry k, Q30 series then rounded to frac bits
  function automatic logic [31:0] sig_entry(int k, int depth, int frac);
    logic [63:0] mag, a, x, sum, term, r, s, one30;
    logic neg;
    int i;
    one30 = 64'd1 << 30;
    neg = (16 * k) < (8 * depth);
    mag = neg ? 64'(8 * depth - 16 * k) : 64'(16 * k - 8 * depth);
    a = udiv(mag << 30, 64'(depth));
    x = a >> 4;
    sum = one30;
    term = one30;
    for (i = 1; i <= 24; i++) begin
      term = udiv((term * x) >> 30, 64'(i));
      sum = sum + term;
    end
    r = udiv(64'd1 << 60, sum);
    for (i = 0; i < 4; i++) begin
      r = (r * r) >> 30;
    end
    if (neg) begin
      s = udiv(r << 30, one30 + r);
    end else begin
      s = udiv(64'd1 << 60, one30 + r);
    end
    s = (s + (64'd1 << (29 - frac))) >> (30 - frac);
    return s[31:0];
  endfunction

endpackage

// ===== design/rlgh_if.sv =====
// Valid/ready channel interfaces for the sample input and result output.
// Depends on rlgh_pkg.
interface rlgh_in_if;
  import rlgh_pkg::*;
  logic                      valid;
  logic                      ready;
  logic signed [SCORE_W-1:0] boost_score;
  logic [TIME_W-1:0]         row_time;
  logic [TIME_W-1:0]         col_time;
  logic                      last_sample;

  modport source (output valid, boost_score, row_time, col_time, last_sample, input ready);
  modport sink (input valid, boost_score, row_time, col_time, last_sample, output ready);
endinterface

interface rlgh_out_if;
  import rlgh_pkg::*;
  logic                     valid;
  logic                     ready;
  logic signed [GRAD_W-1:0] gradient;
  logic [HESS_W-1:0]        hessian;
  logic                     last_result;

  modport source (output valid, gradient, hessian, last_result, input ready);
  modport sink (input valid, gradient, hessian, last_result, output ready);
endinterface

// ===== design/rlgh_lookup.sv =====
// Front of the pipe: sigmoid table index, runtime difference, then a
// registered table read. Depends on rlgh_pkg.
module rlgh_lookup #(
  parameter int FRAC_BITS = rlgh_pkg::FRAC_BITS_DEF,
  parameter int DEPTH     = rlgh_pkg::SIG_DEPTH_DEF
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               in_valid,
  output logic                               in_ready,
  input  logic signed [rlgh_pkg::SCORE_W-1:0] boost_score,
  input  logic [rlgh_pkg::TIME_W-1:0]        row_time,
  input  logic [rlgh_pkg::TIME_W-1:0]        col_time,
  input  logic                               last_sample,
  output logic                               out_valid,
  input  logic                               out_ready,
  output logic [FRAC_BITS:0]                 out_p,
  output logic                               out_cge,
  output rlgh_pkg::lane_t                    out_lane
);
  import rlgh_pkg::*;

  localparam int SW  = FRAC_BITS + 1;
  localparam int IW  = $clog2(DEPTH);
  localparam int TTW = SCORE_W + 2;
  localparam int PW  = SCORE_W + 1 + 16;

  typedef logic [SW-1:0] rom_t [DEPTH];

  function automatic rom_t build_rom();
    rom_t rv;
    int k;
    for (k = 0; k < DEPTH; k++) begin
      rv[k] = SW'(sig_entry(k, DEPTH, FRAC_BITS));
    end
    return rv;
  endfunction

  localparam rom_t SIG_ROM = build_rom();

  logic [1:0]    v_r;
  logic [1:0]    en;
  logic [IW-1:0] idx_a_r, idx_nxt;
  logic          cge_a_r, cge_b_r;
  lane_t         lane_a_r, lane_b_r, lane_nxt;
  logic [SW-1:0] p_b_r;

  logic signed [TTW-1:0] tt;
  logic [PW-1:0]         scaled;
  logic [PW-1:0]         shifted;

  // stall chain
  assign en[1]    = !v_r[1] || out_ready;
  assign en[0]    = !v_r[0] || en[1];
  assign in_ready = en[0];

  // index = floor((z + 8) * DEPTH / 16), saturated to the table
  always_comb begin
    tt      = TTW'(boost_score) + TTW'(8 << FRAC_BITS);
    scaled  = PW'(tt[TTW-2:0]) * PW'(DEPTH);
    shifted = scaled >> (FRAC_BITS + 4);
    if (tt[TTW-1]) begin
      idx_nxt = '0;
    end else if (shifted >= PW'(DEPTH)) begin
      idx_nxt = IW'(DEPTH - 1);
    end else begin
      idx_nxt = shifted[IW-1:0];
    end
    lane_nxt.dpos = col_time > row_time;
    lane_nxt.d    = lane_nxt.dpos ? col_time - row_time : row_time - col_time;
    lane_nxt.last = last_sample;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else begin
      if (en[0]) v_r[0] <= in_valid;
      if (en[1]) v_r[1] <= v_r[0];
    end
  end

  // stage A: index and runtime difference
  always_ff @(posedge clk) begin
    if (en[0]) begin
      idx_a_r  <= idx_nxt;
      cge_a_r  <= col_time >= row_time;
      lane_a_r <= lane_nxt;
    end
  end

  // stage B: table read
  always_ff @(posedge clk) begin
    if (en[1]) begin
      p_b_r    <= SIG_ROM[idx_a_r];
      cge_b_r  <= cge_a_r;
      lane_b_r <= lane_a_r;
    end
  end

  assign out_valid = v_r[1];
  assign out_p     = p_b_r;
  assign out_cge   = cge_b_r;
  assign out_lane  = lane_b_r;

endmodule

// ===== design/rlgh_deriv.sv =====
// Middle of the pipe: p(1-p) terms and the scaled gradient/Hessian
// magnitudes before the runtime factors. Depends on rlgh_pkg.
module rlgh_deriv #(
  parameter int FRAC_BITS = rlgh_pkg::FRAC_BITS_DEF
) (
  input  logic                                    clk,
  input  logic                                    rst_n,
  input  logic                                    in_valid,
  output logic                                    in_ready,
  input  logic [FRAC_BITS:0]                      in_p,
  input  logic                                    in_cge,
  input  rlgh_pkg::lane_t                         in_lane,
  input  logic [rlgh_pkg::SCALE_W-1:0]            scale,
  output logic                                    out_valid,
  input  logic                                    out_ready,
  output logic [FRAC_BITS+rlgh_pkg::MAG_EXTRA-1:0] out_gm,
  output logic [FRAC_BITS+rlgh_pkg::MAG_EXTRA-1:0] out_hm,
  output rlgh_pkg::lane_t                         out_lane
);
  import rlgh_pkg::*;

  localparam int SW  = FRAC_BITS + 1;
  localparam int SPW = FRAC_BITS - 1;
  localparam int MW  = FRAC_BITS + MAG_EXTRA;
  localparam logic [SW-1:0] ONE   = SW'(1) << FRAC_BITS;
  localparam logic [SW:0]   ONE_W = (SW + 1)'(1) << FRAC_BITS;

  logic [3:0] v_r;
  logic [3:0] en;

  // stage C
  logic [SW-1:0]  q_c_r, vmag_c_r;
  logic [SPW-1:0] sp_c_r;
  logic           vneg_c_r;
  lane_t          lane_c_r;
  // stage D
  logic [SPW-1:0] qsp_d_r, sp_d_r;
  logic [SW-1:0]  qv_d_r;
  logic           sub_d_r;
  lane_t          lane_d_r;
  // stage E
  logic [SPW-1:0] qsp_e_r, sk_e_r;
  lane_t          lane_e_r;
  // stage F
  logic [MW-1:0]  gm_f_r, hm_f_r;
  lane_t          lane_f_r;

  logic [SW-1:0]       p_cl, u, q_nxt, vmag_nxt;
  logic [SW:0]         p2;
  logic [2*SW-1:0]     pu, qvp;
  logic [SW+SPW-1:0]   qs, spk;
  logic [SW-1:0]       kmag;
  logic                vneg_nxt;

  // stall chain
  always_comb begin
    en[3] = !v_r[3] || out_ready;
    en[2] = !v_r[2] || en[3];
    en[1] = !v_r[1] || en[2];
    en[0] = !v_r[0] || en[1];
  end
  assign in_ready = en[0];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else begin
      if (en[0]) v_r[0] <= in_valid;
      if (en[1]) v_r[1] <= v_r[0];
      if (en[2]) v_r[2] <= v_r[1];
      if (en[3]) v_r[3] <= v_r[2];
    end
  end

  // stage C: clip p, form 1-p, p(1-p) and |1-2p|
  always_comb begin
    p_cl     = (in_p > ONE) ? ONE : in_p;
    u        = ONE - p_cl;
    q_nxt    = in_cge ? p_cl : u;
    pu       = (2 * SW)'(p_cl) * (2 * SW)'(u);
    p2       = {p_cl, 1'b0};
    vneg_nxt = p2 > ONE_W;
    vmag_nxt = vneg_nxt ? SW'(p2 - ONE_W) : SW'(ONE_W - p2);
  end

  always_ff @(posedge clk) begin
    if (en[0]) begin
      q_c_r    <= q_nxt;
      sp_c_r   <= SPW'(pu >> FRAC_BITS);
      vmag_c_r <= vmag_nxt;
      vneg_c_r <= vneg_nxt;
      lane_c_r <= in_lane;
    end
  end

  // stage D: Q*sp and Q*|1-2p|
  always_comb begin
    qs  = (SW + SPW)'(q_c_r) * (SW + SPW)'(sp_c_r);
    qvp = (2 * SW)'(q_c_r) * (2 * SW)'(vmag_c_r);
  end

  always_ff @(posedge clk) begin
    if (en[1]) begin
      qsp_d_r  <= SPW'(qs >> FRAC_BITS);
      qv_d_r   <= SW'(qvp >> FRAC_BITS);
      sp_d_r   <= sp_c_r;
      sub_d_r  <= lane_c_r.dpos == vneg_c_r;
      lane_d_r <= lane_c_r;
    end
  end

  // stage E: |k| and sp*|k|
  always_comb begin
    if (sub_d_r) begin
      kmag = (SW'(sp_d_r) >= qv_d_r) ? SW'(sp_d_r) - qv_d_r : qv_d_r - SW'(sp_d_r);
    end else begin
      kmag = SW'(sp_d_r) + qv_d_r;
    end
    spk = (SW + SPW)'(sp_d_r) * (SW + SPW)'(kmag);
  end

  always_ff @(posedge clk) begin
    if (en[2]) begin
      qsp_e_r  <= qsp_d_r;
      sk_e_r   <= SPW'(spk >> FRAC_BITS);
      lane_e_r <= lane_d_r;
    end
  end

  // stage F: times 2*scale
  always_ff @(posedge clk) begin
    if (en[3]) begin
      gm_f_r   <= MW'({scale, 1'b0}) * MW'(qsp_e_r);
      hm_f_r   <= MW'({scale, 1'b0}) * MW'(sk_e_r);
      lane_f_r <= lane_e_r;
    end
  end

  assign out_valid = v_r[3];
  assign out_gm    = gm_f_r;
  assign out_hm    = hm_f_r;
  assign out_lane  = lane_f_r;

endmodule

// ===== design/rlgh_scale_clamp.sv =====
// Back of the pipe: two runtime factors, split wide product, saturation,
// clamps and sign; holds the output word. Depends on rlgh_pkg and macros.
`include "assert_macros.svh"
module rlgh_scale_clamp #(
  parameter int FRAC_BITS = rlgh_pkg::FRAC_BITS_DEF
) (
  input  logic                                    clk,
  input  logic                                    rst_n,
  input  logic                                    in_valid,
  output logic                                    in_ready,
  input  logic [FRAC_BITS+rlgh_pkg::MAG_EXTRA-1:0] in_gm,
  input  logic [FRAC_BITS+rlgh_pkg::MAG_EXTRA-1:0] in_hm,
  input  rlgh_pkg::lane_t                         in_lane,
  input  rlgh_pkg::cfg_t                          cfg,
  output logic                                    out_valid,
  input  logic                                    out_ready,
  output logic signed [rlgh_pkg::GRAD_W-1:0]      out_grad,
  output logic [rlgh_pkg::HESS_W-1:0]             out_hess,
  output logic                                    out_last
);
  import rlgh_pkg::*;

  localparam int MW  = FRAC_BITS + MAG_EXTRA;
  localparam int GW  = MW + TIME_W;
  localparam int THI = T_W - TLO_W;
  localparam int PPW = TLO_W + TIME_W;
  localparam int FW  = T_W + TIME_W;
  localparam logic [HESS_W-1:0] SAT = '1;

  logic [2:0] v_r;
  logic [2:0] en;

  logic [T_W-1:0] gt_g_r, ht_g_r;
  lane_t          lane_g_r, lane_h_r;
  logic [PPW-1:0] glo_h_r, ghi_h_r, hlo_h_r, hhi_h_r;
  logic signed [GRAD_W-1:0] grad_r;
  logic [HESS_W-1:0]        hess_r;
  logic                     last_r;

  logic [GW-1:0]     gprod, hprod;
  logic [FW-1:0]     gfull, hfull, gsh, hsh;
  logic [HESS_W-1:0] gmag, hmag, hc, hf;
  logic [CLIP_W-1:0] gc;

  // stall chain
  always_comb begin
    en[2] = !v_r[2] || out_ready;
    en[1] = !v_r[1] || en[2];
    en[0] = !v_r[0] || en[1];
  end
  assign in_ready = en[0];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else begin
      if (en[0]) v_r[0] <= in_valid;
      if (en[1]) v_r[1] <= v_r[0];
      if (en[2]) v_r[2] <= v_r[1];
    end
  end

  // stage G: first runtime factor
  always_comb begin
    gprod = GW'(in_gm) * GW'(in_lane.d);
    hprod = GW'(in_hm) * GW'(in_lane.d);
  end

  always_ff @(posedge clk) begin
    if (en[0]) begin
      gt_g_r   <= T_W'(gprod >> FRAC_BITS);
      ht_g_r   <= T_W'(hprod >> FRAC_BITS);
      lane_g_r <= in_lane;
    end
  end

  // stage H: second factor as low/high partial products
  always_ff @(posedge clk) begin
    if (en[1]) begin
      glo_h_r  <= PPW'(gt_g_r[TLO_W-1:0]) * PPW'(lane_g_r.d);
      ghi_h_r  <= PPW'(gt_g_r[T_W-1:TLO_W]) * PPW'(lane_g_r.d);
      hlo_h_r  <= PPW'(ht_g_r[TLO_W-1:0]) * PPW'(lane_g_r.d);
      hhi_h_r  <= PPW'(ht_g_r[T_W-1:TLO_W]) * PPW'(lane_g_r.d);
      lane_h_r <= lane_g_r;
    end
  end

  // stage I: sum, shift, saturate, clamp, sign
  always_comb begin
    gfull = (FW'(ghi_h_r) << TLO_W) + FW'(glo_h_r);
    hfull = (FW'(hhi_h_r) << TLO_W) + FW'(hlo_h_r);
    gsh   = gfull >> FRAC_BITS;
    hsh   = hfull >> FRAC_BITS;
    gmag  = (gsh > FW'(SAT)) ? SAT : gsh[HESS_W-1:0];
    hmag  = (hsh > FW'(SAT)) ? SAT : hsh[HESS_W-1:0];
    hc    = (hmag < cfg.ceil_v) ? hmag : cfg.ceil_v;
    hf    = (hc < cfg.floor_v) ? cfg.floor_v : hc;
    gc    = (gmag > HESS_W'(cfg.clip)) ? cfg.clip : gmag[CLIP_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (en[2]) begin
      grad_r <= lane_h_r.dpos ? GRAD_W'(gc) : GRAD_W'(0) - GRAD_W'(gc);
      hess_r <= hf;
      last_r <= lane_h_r.last;
    end
  end

  assign out_valid = v_r[2];
  assign out_grad  = grad_r;
  assign out_hess  = hess_r;
  assign out_last  = last_r;

  `RLGH_ASSERT(a_hess_floor, out_valid |-> (out_hess >= cfg.floor_v), "hessian below floor")
  `RLGH_ASSERT(a_grad_clip, out_valid |-> ((out_grad[GRAD_W-1] ? GRAD_W'(0) - out_grad : out_grad) <= GRAD_W'(cfg.clip)), "gradient past clip")
  `RLGH_ASSERT(a_mid_hold, (v_r[1] && !en[1]) |=> (v_r[1] && $stable(glo_h_r) && $stable(hhi_h_r)), "blocked stage lost its word")

endmodule

// ===== design/runtime_loss_grad_hess.sv =====
// Top level of the runtime loss gradient/Hessian pipeline: config registers
// and the three pipe sections. Depends on rlgh_pkg, rlgh_if and submodules.
//
// Use: one sample word (boost_score, row_time, col_time, last_sample) enters
// on in_ch; one result word (gradient, hessian, last_result) leaves on out_ch,
// in order. Both channels move a word when valid and ready are high at a
// rising clock edge.
// Throughput: one word per cycle while out_ch.ready stays high.
// Pipeline: 9 register stages (2 lookup stages with the registered sigmoid
// table read, 4 derivative stages, 3 runtime-factor and clamp stages, the
// last of which is the output register). The accepting edge loads the first,
// and out_ch.valid rises when the word reaches the output register.
// Config: cfg_we writes cfg_data into register cfg_index (0 scale, 1 gradient
// clip, 2 Hessian floor, 3 Hessian ceiling); write only while the pipe is empty.
// Reset (rst_n low, synchronous) empties the pipe and loads register defaults.
// Stall: when out_ch.ready is low the result holds and words pile up in the
// stages behind it; in_ch.ready drops only once every stage holds a word.
module runtime_loss_grad_hess #(
  parameter int FRAC_BITS           = rlgh_pkg::FRAC_BITS_DEF,
  parameter int SIGMOID_TABLE_DEPTH = rlgh_pkg::SIG_DEPTH_DEF
) (
  input  logic                              clk,
  input  logic                              rst_n,
  rlgh_in_if.sink                           in_ch,
  rlgh_out_if.source                        out_ch,
  input  logic                              cfg_we,
  input  logic [rlgh_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [rlgh_pkg::CFG_DATA_W-1:0]   cfg_data
);
  import rlgh_pkg::*;

  localparam int SW = FRAC_BITS + 1;
  localparam int MW = FRAC_BITS + MAG_EXTRA;

  cfg_t cfg_r;

  logic          lk_valid, lk_ready;
  logic [SW-1:0] lk_p;
  logic          lk_cge;
  lane_t         lk_lane;
  logic          dv_valid, dv_ready;
  logic [MW-1:0] dv_gm, dv_hm;
  lane_t         dv_lane;

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.scale   <= RST_SCALE;
      cfg_r.clip    <= RST_CLIP;
      cfg_r.floor_v <= RST_FLOOR;
      cfg_r.ceil_v  <= RST_CEIL;
    end else if (cfg_we) begin
      unique case (cfg_reg_t'(cfg_index))
        REG_SCALE: cfg_r.scale   <= cfg_data[SCALE_W-1:0];
        REG_CLIP:  cfg_r.clip    <= cfg_data[CLIP_W-1:0];
        REG_FLOOR: cfg_r.floor_v <= cfg_data[HESS_W-1:0];
        REG_CEIL:  cfg_r.ceil_v  <= cfg_data[HESS_W-1:0];
        default: ;
      endcase
    end
  end

  rlgh_lookup #(
    .FRAC_BITS (FRAC_BITS),
    .DEPTH     (SIGMOID_TABLE_DEPTH)
  ) u_lookup (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_ch.valid),
    .in_ready    (in_ch.ready),
    .boost_score (in_ch.boost_score),
    .row_time    (in_ch.row_time),
    .col_time    (in_ch.col_time),
    .last_sample (in_ch.last_sample),
    .out_valid   (lk_valid),
    .out_ready   (lk_ready),
    .out_p       (lk_p),
    .out_cge     (lk_cge),
    .out_lane    (lk_lane)
  );

  rlgh_deriv #(
    .FRAC_BITS (FRAC_BITS)
  ) u_deriv (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (lk_valid),
    .in_ready  (lk_ready),
    .in_p      (lk_p),
    .in_cge    (lk_cge),
    .in_lane   (lk_lane),
    .scale     (cfg_r.scale),
    .out_valid (dv_valid),
    .out_ready (dv_ready),
    .out_gm    (dv_gm),
    .out_hm    (dv_hm),
    .out_lane  (dv_lane)
  );

  rlgh_scale_clamp #(
    .FRAC_BITS (FRAC_BITS)
  ) u_scale_clamp (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (dv_valid),
    .in_ready  (dv_ready),
    .in_gm     (dv_gm),
    .in_hm     (dv_hm),
    .in_lane   (dv_lane),
    .cfg       (cfg_r),
    .out_valid (out_ch.valid),
    .out_ready (out_ch.ready),
    .out_grad  (out_ch.gradient),
    .out_hess  (out_ch.hessian),
    .out_last  (out_ch.last_result)
  );

endmodule
